FILE: rtl/maf_pkg.sv
// shared types and constants of the moving average filter
`default_nettype none

package maf_pkg;

   // width of the window length register word
   localparam int CFG_BITS = 7;

   // window length after reset
   localparam int WINDOW_RESET = 8;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH
   } maf_state_type;

endpackage

`default_nettype wire

FILE: rtl/maf_if.sv
// channel interfaces of the moving average filter: sample, average and csr
`default_nettype none

// input sample channel
interface maf_sample_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// result average channel
interface maf_average_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] average;

   modport source (output valid, output average, input ready);
   modport sink   (input valid, input average, output ready);
endinterface

// window length register write channel
interface maf_csr_if;
   import maf_pkg::*;

   logic                valid;
   logic                ready;
   logic [CFG_BITS-1:0] window_length;

   modport source (output valid, output window_length, input ready);
   modport sink   (input valid, input window_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/moving_average_filter.sv
// moving average filter top level: ring store, running sum and bit-serial divider
`default_nettype none

// Moving average over the last window_length signed samples (1 to WINDOW_MAX),
// truncated toward zero; slots not yet filled since the last clear count as zero.
// Each req word yields exactly one rsp word. One sample is handled at a time, in
// order: the ring read, the running sum update, SUM_BITS steps of the
// one-bit-per-cycle restoring divider, and the hand-over to the output register.
// The output register lets a new sample be taken while the previous average
// still waits on rsp. Writing window_length on csr (0 reads as 1, values above
// WINDOW_MAX saturate) clears the window, the sum and the write position; csr is
// always ready, and it is to be written only while the block is idle, which the
// block itself does not enforce.
module moving_average_filter #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   maf_sample_if.sink        req,
   maf_average_if.source     rsp,
   maf_csr_if.sink           csr
);
   import maf_pkg::*;

   localparam int POS_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int LEN_BITS = $clog2(WINDOW_MAX + 1);
   localparam int SUM_BITS = SAMPLE_BITS + POS_BITS + 1;
   localparam int CNT_BITS = $clog2(SUM_BITS);
   localparam int LEN_RESET = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;

   // sample ring
   logic signed [SAMPLE_BITS-1:0] ring_mem [WINDOW_MAX];

   maf_state_type                 state_ff, state_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic [POS_BITS-1:0]           pos_ff, pos_in;
   logic [LEN_BITS-1:0]           len_ff, len_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic                          wrapped_ff, wrapped_in;
   logic [SUM_BITS-1:0]           dq_ff, dq_in;
   logic [LEN_BITS-1:0]           rem_ff, rem_in;
   logic [CNT_BITS-1:0]           cnt_ff, cnt_in;
   logic                          neg_ff, neg_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] avg_ff, avg_in;

   logic                          req_take;
   logic                          ring_we;
   logic signed [SAMPLE_BITS-1:0] old_sample;
   logic signed [SUM_BITS-1:0]    sum_new;
   logic [LEN_BITS-1:0]           pos_inc;
   logic [LEN_BITS:0]             trial;
   logic [LEN_BITS:0]             trial_diff;
   logic [SAMPLE_BITS-1:0]        quo_low;
   logic [31:0]                   cfg_wide;

   // handshake outputs
   assign req.ready   = (state_ff == ST_IDLE);
   assign req_take    = req.valid && req.ready;
   assign csr.ready   = 1'b1;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.average = avg_ff;

   // ring store, registered read at the write position
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[pos_ff] <= sample_ff;
      end
      if (req_take) begin
         rd_data_ff <= ring_mem[pos_ff];
      end
   end

   // datapath helpers
   assign ring_we    = (state_ff == ST_UPDATE);
   assign old_sample = wrapped_ff ? rd_data_ff : '0;
   assign sum_new    = sum_ff - SUM_BITS'(old_sample) + SUM_BITS'(sample_ff);
   assign pos_inc    = LEN_BITS'(pos_ff) + LEN_BITS'(1);
   assign trial      = {rem_ff, dq_ff[SUM_BITS-1]};
   assign trial_diff = trial - {1'b0, len_ff};
   assign quo_low    = dq_ff[SAMPLE_BITS-1:0];
   assign cfg_wide   = 32'(csr.window_length);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and data registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         len_ff       <= LEN_BITS'(LEN_RESET);
         sum_ff       <= '0;
         wrapped_ff   <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         sum_ff       <= sum_in;
         wrapped_ff   <= wrapped_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff <= sample_in;
      dq_ff     <= dq_in;
      rem_ff    <= rem_in;
      neg_ff    <= neg_in;
      avg_ff    <= avg_in;
   end

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      sum_in       = sum_ff;
      wrapped_in   = wrapped_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               sample_in = req.sample;
               state_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // running sum, position advance, divider load with |sum|
            sum_in = sum_new;
            if (pos_inc >= len_ff) begin
               pos_in     = '0;
               wrapped_in = 1'b1;
            end else begin
               pos_in = pos_inc[POS_BITS-1:0];
            end
            neg_in   = sum_new[SUM_BITS-1];
            dq_in    = sum_new[SUM_BITS-1] ? SUM_BITS'(-sum_new) : SUM_BITS'(sum_new);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // one restoring step: quotient bit shifts in from the right
            if (!trial_diff[LEN_BITS]) begin
               rem_in = trial_diff[LEN_BITS-1:0];
               dq_in  = {dq_ff[SUM_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial[LEN_BITS-1:0];
               dq_in  = {dq_ff[SUM_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(SUM_BITS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // restore the sign and hand over once the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               avg_in       = neg_ff ? -$signed(quo_low) : $signed(quo_low);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // window length write clears the window
      if (csr.valid) begin
         if (cfg_wide == 32'd0) begin
            len_in = LEN_BITS'(1);
         end else if (cfg_wide > 32'(WINDOW_MAX)) begin
            len_in = LEN_BITS'(WINDOW_MAX);
         end else begin
            len_in = LEN_BITS'(cfg_wide);
         end
         pos_in     = '0;
         sum_in     = '0;
         wrapped_in = 1'b0;
      end
   end

endmodule

`default_nettype wire
